FILE: rtl/core/sample_voice_resampler_unit_assert.svh
// Assertion macros for the sample voice resampler.
// Used by the top level only; no other dependencies.
`ifndef SAMPLE_VOICE_RESAMPLER_UNIT_ASSERT_SVH
`define SAMPLE_VOICE_RESAMPLER_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SVRU_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("svru: same-cycle check failed");

// next-cycle implication, checked outside reset
`define SVRU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("svru: next-cycle check failed");

`endif

FILE: rtl/core/svru_pkg.sv
// Shared types and codes of the sample voice resampler.
// No dependencies.
package svru_pkg;

    localparam int SAMPLE_DEPTH_DEF = 65536;
    localparam int MAX_PITCH_DEF    = 16;
    localparam int Q_DEPTH          = 2;

    // item kinds
    localparam logic [1:0] KIND_LOAD   = 2'd0;
    localparam logic [1:0] KIND_SET    = 2'd1;
    localparam logic [1:0] KIND_RENDER = 2'd2;

    // control setting selects
    localparam logic [2:0] SEL_GAIN   = 3'd0;
    localparam logic [2:0] SEL_PITCH  = 3'd1;
    localparam logic [2:0] SEL_LOOP   = 3'd2;
    localparam logic [2:0] SEL_FILTER = 3'd3;
    localparam logic [2:0] SEL_A0     = 3'd4;
    localparam logic [2:0] SEL_A1     = 3'd5;
    localparam logic [2:0] SEL_B12    = 3'd6;
    localparam logic [2:0] SEL_POS    = 3'd7;

    typedef struct packed {
        logic [1:0]          kind;
        logic [15:0]         addr;
        logic signed [15:0]  sample;
        logic [2:0]          sel;
        logic signed [31:0]  setv;
        logic signed [31:0]  mixl;
        logic signed [31:0]  mixr;
    } t_item;

    typedef struct packed {
        logic [15:0] loop_start;
        logic [15:0] loop_end;
        logic [16:0] sample_end;
        logic        output_mode;
        logic [15:0] pan_left;
        logic [15:0] pan_right;
    } t_cfg;

    typedef struct packed {
        logic pop;
        logic out_load;
    } t_back_stat;

endpackage

FILE: rtl/core/sample_voice_resampler_unit.sv
// Wavetable voice with Hermite and box-average resampling.
// A load or set beat is written into the queue and then dispatched from the idle state.
// A render beat at pitch up to 1.0 makes four store reads through the single
// registered read port, then runs the render sequencer, which runs every variable multiply
// through one shared multiplier (the filter and the stereo pan add sequencer states).
// Above pitch 1.0 it instead reads the box samples and runs a bit-serial divide, then
// the same tail. The sample store is undefined until loaded and needs no clearing
// pass after reset.
// Depends on svru_pkg, svru_front, svru_back and the assertion macro header.
`include "sample_voice_resampler_unit_assert.svh"

module sample_voice_resampler_unit import svru_pkg::*; #(
    parameter int SAMPLE_DEPTH = SAMPLE_DEPTH_DEF,
    parameter int MAX_PITCH    = MAX_PITCH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_addr,
    input  logic [16:0]        i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_kind,
    input  logic [15:0]        i_sample_addr,
    input  logic signed [15:0] i_sample_value,
    input  logic [2:0]         i_setting_select,
    input  logic signed [31:0] i_setting_value,
    input  logic signed [31:0] i_mix_left_in,
    input  logic signed [31:0] i_mix_right_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_mix_left_out,
    output logic signed [31:0] o_mix_right_out,
    output logic               o_finished
);
    localparam logic [2:0] CFG_LOOP_START = 3'd0;
    localparam logic [2:0] CFG_LOOP_END   = 3'd1;
    localparam logic [2:0] CFG_SAMPLE_END = 3'd2;
    localparam logic [2:0] CFG_MODE       = 3'd3;
    localparam logic [2:0] CFG_PAN_LEFT   = 3'd4;
    localparam logic [2:0] CFG_PAN_RIGHT  = 3'd5;

    t_cfg       r_cfg;
    t_item      w_item, w_head;
    logic       w_head_valid;
    t_back_stat w_bstat;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{loop_start: 16'd0, loop_end: 16'd0, sample_end: 17'd1,
                       output_mode: 1'b0, pan_left: 16'd32768, pan_right: 16'd32768};
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_LOOP_START: r_cfg.loop_start  <= i_cfg_wdata[15:0];
                CFG_LOOP_END:   r_cfg.loop_end    <= i_cfg_wdata[15:0];
                CFG_SAMPLE_END: r_cfg.sample_end  <= i_cfg_wdata;
                CFG_MODE:       r_cfg.output_mode <= i_cfg_wdata[0];
                CFG_PAN_LEFT:   r_cfg.pan_left    <= i_cfg_wdata[15:0];
                CFG_PAN_RIGHT:  r_cfg.pan_right   <= i_cfg_wdata[15:0];
                default:        r_cfg <= r_cfg;
            endcase
        end
    end

    assign w_item = '{kind: i_kind, addr: i_sample_addr, sample: i_sample_value,
                      sel: i_setting_select, setv: i_setting_value,
                      mixl: i_mix_left_in, mixr: i_mix_right_in};

    svru_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_item       (w_item),
        .i_pop        (w_bstat.pop),
        .o_head_valid (w_head_valid),
        .o_head       (w_head)
    );

    svru_back #(
        .SAMPLE_DEPTH (SAMPLE_DEPTH),
        .MAX_PITCH    (MAX_PITCH)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_head_valid    (w_head_valid),
        .i_head          (w_head),
        .o_stat          (w_bstat),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_mix_left_out  (o_mix_left_out),
        .o_mix_right_out (o_mix_right_out),
        .o_finished      (o_finished)
    );

    // queue is never popped empty
    `SVRU_ASSERT_IMPL(a_pop_nonempty, i_clk, i_rst_n, w_bstat.pop, w_head_valid)
    // a result is loaded only into a free or draining output register
    `SVRU_ASSERT_IMPL(a_load_free, i_clk, i_rst_n, w_bstat.out_load, (!o_out_valid || i_out_ready))
    // a taken result without a new load leaves the output empty
    `SVRU_ASSERT_NEXT(a_out_drain, i_clk, i_rst_n, (o_out_valid && i_out_ready && !w_bstat.out_load), !o_out_valid)
endmodule

FILE: rtl/core/svru_front.sv
// Front end: accepts input beats, drops unknown kinds, queues the rest.
// Depends on svru_pkg.
module svru_front import svru_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_item i_item,
    input  logic  i_pop,
    output logic  o_head_valid,
    output t_item o_head
);
    localparam int QAW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int QCW = $clog2(Q_DEPTH + 1);

    t_item            r_q [Q_DEPTH];
    logic [QAW-1:0]   r_wp, r_rp;
    logic [QCW-1:0]   r_cnt;
    logic             w_push;

    assign o_in_ready   = (r_cnt != QCW'(Q_DEPTH));
    assign o_head_valid = (r_cnt != '0);
    assign o_head       = r_q[r_rp];

    // classify: kind 3 is taken and dropped
    assign w_push = i_in_valid && o_in_ready &&
                    ((i_item.kind == KIND_LOAD) || (i_item.kind == KIND_SET) ||
                     (i_item.kind == KIND_RENDER));

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= i_item;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == QAW'(Q_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == QAW'(Q_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            case ({w_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end
endmodule

FILE: rtl/core/svru_back.sv
// Back end: voice state, sample store, render sequencer and output register.
// Depends on svru_pkg.
module svru_back import svru_pkg::*; #(
    parameter int SAMPLE_DEPTH = SAMPLE_DEPTH_DEF,
    parameter int MAX_PITCH    = MAX_PITCH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_head_valid,
    input  t_item              i_head,
    output t_back_stat         o_stat,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_mix_left_out,
    output logic signed [31:0] o_mix_right_out,
    output logic               o_finished
);
    localparam int AW  = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
    localparam int CW  = $clog2(MAX_PITCH + 2);
    localparam int SW  = 16 + CW;
    localparam int DVW = SW + 8;
    localparam int KW  = $clog2(DVW + 1);
    localparam logic [23:0] PITCH_MAX = 24'(MAX_PITCH) << 16;
    localparam logic [23:0] PITCH_ONE = 24'h010000;

    // sequencer states
    localparam logic [4:0] S_IDLE = 5'd0,  S_START = 5'd1,  S_HRD = 5'd2,  S_H0 = 5'd3,
                           S_H1   = 5'd4,  S_H2    = 5'd5,  S_H3  = 5'd6,  S_H4 = 5'd7,
                           S_H5   = 5'd8,  S_H6    = 5'd9,  S_BRD = 5'd10, S_DIV = 5'd11,
                           S_DV2  = 5'd12, S_F1    = 5'd13, S_F2  = 5'd14, S_F3 = 5'd15,
                           S_F4   = 5'd16, S_F5    = 5'd17, S_F6  = 5'd18, S_GM = 5'd19,
                           S_GL   = 5'd20, S_GR    = 5'd21, S_GV  = 5'd22, S_AL = 5'd23,
                           S_AR   = 5'd24, S_POS   = 5'd25, S_PW  = 5'd26, S_OUT = 5'd27;

    function automatic logic signed [31:0] sat32(input logic signed [35:0] x);
        if (x > 36'sd2147483647) return 32'sh7FFFFFFF;
        else if (x < -36'sd2147483648) return 32'sh80000000;
        else return x[31:0];
    endfunction

    // round half up by 2^s
    function automatic logic signed [72:0] rsh(input logic signed [72:0] x, input int s);
        return (x + (73'sd1 <<< (s - 1))) >>> s;
    endfunction

    logic [4:0]  r_state;

    // voice state
    logic [15:0]        r_gain;
    logic [23:0]        r_pitch;
    logic               r_loop_on, r_filter_on;
    logic signed [31:0] r_a0, r_a1;
    logic signed [15:0] r_b1, r_b2;
    logic [31:0]        r_pos;
    logic signed [31:0] r_h1, r_h2;

    // work registers
    logic signed [31:0] r_mixl, r_mixr, r_left, r_right, r_val, r_y;
    logic               r_fin;
    logic [16:0]        r_ix [4];
    logic signed [15:0] r_p [4];
    logic [KW-1:0]      r_k;
    logic signed [19:0] r_c3, r_c2;
    logic signed [16:0] r_c1;
    logic signed [39:0] r_u;
    logic signed [72:0] r_prod;
    logic signed [33:0] r_fwd, r_ff1, r_t1;
    logic [17:0]        r_gl, r_gr;
    logic [32:0]        r_np;
    logic signed [19:0] r_bi;
    logic [CW-1:0]      r_brem, r_cnt;
    logic               r_pend;
    logic signed [SW-1:0] r_sum;
    logic               r_neg;
    logic [DVW-1:0]     r_quo;
    logic [CW-1:0]      r_rem;

    // output register
    logic               r_out_valid;
    logic signed [31:0] r_out_l, r_out_r;
    logic               r_out_fin;

    // sample store
    logic signed [15:0] r_mem [SAMPLE_DEPTH];
    logic signed [15:0] r_mem_q;
    logic               r_rd_ok;

    logic               w_pop, w_load, w_lp, w_done;
    logic [16:0]        w_end1, w_i1, w_i0, w_i2, w_i3, w_raddr, w_bj0, w_bj1, w_bj;
    logic [31:0]        w_raddr_ext, w_waddr_ext;
    logic               w_we;
    logic signed [15:0] w_rdata;
    logic [1:0]         w_cap;
    logic signed [34:0] w_ts, w_ps, w_lo, w_hi, w_bcnt;
    logic signed [39:0] w_ma;
    logic signed [32:0] w_mb;
    logic signed [72:0] w_prod;
    logic [4:0]         w_after_val;
    logic [CW:0]        w_trial;
    logic [32:0]        w_lim, w_np2;
    logic signed [DVW-1:0] w_dvd;
    logic signed [DVW:0]   w_qs;

    assign o_out_valid     = r_out_valid;
    assign o_mix_left_out  = r_out_l;
    assign o_mix_right_out = r_out_r;
    assign o_finished      = r_out_fin;

    assign w_pop  = (r_state == S_IDLE) && i_head_valid;
    assign w_load = (r_state == S_OUT) && (!r_out_valid || i_out_ready);
    assign o_stat = '{pop: w_pop, out_load: w_load};

    assign w_lp   = r_loop_on && (i_cfg.loop_start <= i_cfg.loop_end);
    assign w_done = ({1'b0, r_pos} >= {i_cfg.sample_end, 16'b0});
    assign w_end1 = i_cfg.sample_end - 17'd1;

    // Hermite neighbor indices with loop wrap and end clamp
    always_comb begin
        w_i1 = {1'b0, r_pos[31:16]};
        w_i0 = (w_i1 != '0) ? w_i1 - 17'd1 : '0;
        w_i2 = w_i1 + 17'd1;
        w_i3 = w_i1 + 17'd2;
        if (w_lp && (w_i1 > {1'b0, i_cfg.loop_end})) begin
            w_i2 = {1'b0, i_cfg.loop_start};
            w_i3 = {1'b0, i_cfg.loop_start} + 17'd1;
        end
        if (w_i2 > w_end1) w_i2 = w_end1;
        if (w_i3 > w_end1) w_i3 = w_end1;
    end

    // box bounds around the position
    assign w_ts   = $signed({2'b0, r_pos, 1'b0});
    assign w_ps   = $signed({11'b0, r_pitch});
    assign w_lo   = -((w_ps - w_ts) >>> 17);
    assign w_hi   = (w_ts + w_ps) >>> 17;
    assign w_bcnt = w_hi - w_lo + 35'sd1;

    // box sample index
    always_comb begin
        w_bj0 = r_bi[19] ? '0 : r_bi[16:0];
        w_bj1 = w_bj0;
        if (w_lp && (w_bj0 > {1'b0, i_cfg.loop_end})) begin
            w_bj1 = w_bj0 - {1'b0, i_cfg.loop_end} + {1'b0, i_cfg.loop_start} - 17'd1;
        end
        w_bj = (w_bj1 > w_end1) ? w_end1 : w_bj1;
    end

    // store ports
    assign w_raddr     = (r_state == S_BRD) ? w_bj : r_ix[r_k[1:0]];
    assign w_raddr_ext = {15'b0, w_raddr};
    assign w_waddr_ext = {16'b0, i_head.addr};
    assign w_we        = w_pop && (i_head.kind == KIND_LOAD) &&
                         (w_waddr_ext < 32'(SAMPLE_DEPTH));
    assign w_rdata     = r_rd_ok ? r_mem_q : 16'sd0;
    assign w_cap       = 2'(r_k - 1'b1);

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr_ext[AW-1:0]] <= i_head.sample;
        end
        r_mem_q <= r_mem[w_raddr_ext[AW-1:0]];
        r_rd_ok <= (w_raddr_ext < 32'(SAMPLE_DEPTH));
    end

    // shared multiplier operand selection
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            S_H1:       begin w_ma = 40'(r_c3); w_mb = $signed({17'b0, r_pos[15:0]}); end
            S_H3, S_H5: begin w_ma = r_u;       w_mb = $signed({17'b0, r_pos[15:0]}); end
            S_F1:       begin w_ma = 40'(r_val); w_mb = 33'(r_a0); end
            S_F2:       begin w_ma = 40'(r_val); w_mb = 33'(r_a1); end
            S_F4:       begin w_ma = 40'(r_y);   w_mb = 33'($signed({r_b1, 16'b0})); end
            S_F5:       begin w_ma = 40'(r_y);   w_mb = 33'($signed({r_b2, 16'b0})); end
            S_GM:       begin w_ma = 40'(r_val); w_mb = $signed({17'b0, r_gain}); end
            S_GL:       begin w_ma = $signed({24'b0, r_gain});
                              w_mb = $signed({17'b0, i_cfg.pan_left}); end
            S_GR:       begin w_ma = $signed({24'b0, r_gain});
                              w_mb = $signed({17'b0, i_cfg.pan_right}); end
            S_GV:       begin w_ma = 40'(r_val); w_mb = $signed({15'b0, r_gl}); end
            S_AL:       begin w_ma = 40'(r_val); w_mb = $signed({15'b0, r_gr}); end
            default:    begin w_ma = '0; w_mb = '0; end
        endcase
    end
    assign w_prod = w_ma * w_mb;

    assign w_after_val = r_filter_on ? S_F1 : (i_cfg.output_mode ? S_GL : S_GM);

    // divider step, position wrap, box dividend
    assign w_trial = {r_rem, r_quo[DVW-1]};
    assign w_lim   = {({1'b0, i_cfg.loop_end} + 17'd1), 16'b0};
    assign w_np2   = (w_lp && (r_np >= w_lim)) ?
                     r_np - {({1'b0, i_cfg.loop_end} - {1'b0, i_cfg.loop_start} + 17'd1),
                             16'b0} : r_np;
    assign w_dvd   = {r_sum, 8'b0};
    assign w_qs    = $signed({1'b0, r_quo});

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_gain      <= '0;
            r_pitch     <= PITCH_ONE;
            r_loop_on   <= 1'b0;
            r_filter_on <= 1'b0;
            r_a0        <= '0;
            r_a1        <= '0;
            r_b1        <= '0;
            r_b2        <= '0;
            r_pos       <= '0;
            r_h1        <= '0;
            r_h2        <= '0;
        end else begin
            r_prod <= w_prod;
            if (r_out_valid && i_out_ready && !w_load) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_pop) begin
                        if (i_head.kind == KIND_SET) begin
                            case (i_head.sel)
                                SEL_GAIN:   r_gain <= i_head.setv[15:0];
                                SEL_PITCH:  r_pitch <= (i_head.setv[23:0] > PITCH_MAX) ?
                                                       PITCH_MAX : i_head.setv[23:0];
                                SEL_LOOP:   r_loop_on <= i_head.setv[0];
                                SEL_FILTER: r_filter_on <= i_head.setv[0];
                                SEL_A0:     r_a0 <= i_head.setv;
                                SEL_A1:     r_a1 <= i_head.setv;
                                SEL_B12: begin
                                    r_b1 <= i_head.setv[31:16];
                                    r_b2 <= i_head.setv[15:0];
                                end
                                default: begin
                                    r_pos <= i_head.setv;
                                    r_h1  <= '0;
                                    r_h2  <= '0;
                                end
                            endcase
                        end else if (i_head.kind == KIND_RENDER) begin
                            r_mixl  <= i_head.mixl;
                            r_mixr  <= i_head.mixr;
                            r_state <= S_START;
                        end
                    end
                end
                S_START: begin
                    r_left  <= r_mixl;
                    r_right <= r_mixr;
                    r_fin   <= w_done;
                    r_k     <= '0;
                    if (w_done) begin
                        r_state <= S_OUT;
                    end else if (r_pitch <= PITCH_ONE) begin
                        r_ix[0] <= w_i0;
                        r_ix[1] <= w_i1;
                        r_ix[2] <= w_i2;
                        r_ix[3] <= w_i3;
                        r_state <= S_HRD;
                    end else begin
                        r_bi    <= 20'(w_lo);
                        r_brem  <= (w_bcnt < 35'sd1) ? '0 : CW'(w_bcnt);
                        r_cnt   <= (w_bcnt < 35'sd1) ? CW'(1) : CW'(w_bcnt);
                        r_sum   <= '0;
                        r_pend  <= 1'b0;
                        r_state <= S_BRD;
                    end
                end
                // four neighbor reads; the registered store returns each word the beat after its address
                S_HRD: begin
                    if (r_k != '0) r_p[w_cap] <= w_rdata;
                    if (r_k == KW'(4)) r_state <= S_H0;
                    else r_k <= r_k + 1'b1;
                end
                S_H0: begin
                    r_c3 <= -20'(r_p[0]) + 20'sd3 * 20'(r_p[1]) - 20'sd3 * 20'(r_p[2])
                            + 20'(r_p[3]);
                    r_c2 <= 20'sd2 * 20'(r_p[0]) - 20'sd5 * 20'(r_p[1])
                            + 20'sd4 * 20'(r_p[2]) - 20'(r_p[3]);
                    r_c1 <= 17'(r_p[2]) - 17'(r_p[0]);
                    r_state <= S_H1;
                end
                S_H1: r_state <= S_H2;
                S_H2: begin
                    r_u     <= 40'(r_prod) + (40'(r_c2) <<< 16);
                    r_state <= S_H3;
                end
                S_H3: r_state <= S_H4;
                S_H4: begin
                    r_u     <= 40'(r_prod >>> 16) + (40'(r_c1) <<< 16);
                    r_state <= S_H5;
                end
                S_H5: r_state <= S_H6;
                S_H6: begin
                    r_val   <= 32'((41'(r_p[1]) <<< 8) + 41'(rsh(r_prod, 25)));
                    r_state <= w_after_val;
                end
                // box sum, one store read per beat
                S_BRD: begin
                    if (r_brem != '0) begin
                        r_bi   <= r_bi + 20'sd1;
                        r_brem <= r_brem - 1'b1;
                    end
                    r_pend <= (r_brem != '0);
                    if (r_pend) r_sum <= r_sum + SW'(w_rdata);
                    if ((r_brem == '0) && !r_pend) begin
                        r_neg   <= r_sum[SW-1];
                        r_quo   <= r_sum[SW-1] ? DVW'(-w_dvd) : DVW'(w_dvd);
                        r_rem   <= '0;
                        r_k     <= '0;
                        r_state <= S_DIV;
                    end
                end
                // restoring divide of the magnitude, one bit per beat
                S_DIV: begin
                    if (w_trial >= {1'b0, r_cnt}) begin
                        r_rem <= CW'(w_trial - {1'b0, r_cnt});
                        r_quo <= {r_quo[DVW-2:0], 1'b1};
                    end else begin
                        r_rem <= CW'(w_trial);
                        r_quo <= {r_quo[DVW-2:0], 1'b0};
                    end
                    r_k <= r_k + 1'b1;
                    if (r_k == KW'(DVW - 1)) r_state <= S_DV2;
                end
                S_DV2: begin
                    r_val   <= r_neg ? 32'(-w_qs) : 32'(w_qs);
                    r_state <= w_after_val;
                end
                // biquad filter
                S_F1: r_state <= S_F2;
                S_F2: begin
                    r_fwd   <= 34'(rsh(r_prod, 30));
                    r_state <= S_F3;
                end
                S_F3: begin
                    r_ff1   <= 34'(rsh(r_prod, 30));
                    r_y     <= sat32(36'(r_fwd) + 36'(r_h1));
                    r_state <= S_F4;
                end
                S_F4: r_state <= S_F5;
                S_F5: begin
                    r_t1    <= 34'(rsh(r_prod, 30));
                    r_state <= S_F6;
                end
                S_F6: begin
                    r_h1    <= sat32(36'(r_ff1) + 36'(r_h2) - 36'(r_t1));
                    r_h2    <= sat32(36'(r_fwd) - 36'(rsh(r_prod, 30)));
                    r_val   <= r_y;
                    r_state <= i_cfg.output_mode ? S_GL : S_GM;
                end
                // gain and pan
                S_GM: r_state <= S_AL;
                S_GL: r_state <= S_GR;
                S_GR: begin
                    r_gl    <= 18'(rsh(r_prod, 15));
                    r_state <= S_GV;
                end
                S_GV: begin
                    r_gr    <= 18'(rsh(r_prod, 15));
                    r_state <= S_AL;
                end
                S_AL: begin
                    r_left  <= sat32(36'(r_mixl) + 36'(rsh(r_prod, 20)));
                    r_state <= i_cfg.output_mode ? S_AR : S_POS;
                end
                S_AR: begin
                    r_right <= sat32(36'(r_mixr) + 36'(rsh(r_prod, 20)));
                    r_state <= S_POS;
                end
                // advance and wrap position
                S_POS: begin
                    r_np    <= {1'b0, r_pos} + {9'b0, r_pitch};
                    r_state <= S_PW;
                end
                S_PW: begin
                    r_pos   <= w_np2[32] ? 32'hFFFFFFFF : w_np2[31:0];
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (w_load) begin
                        r_out_valid <= 1'b1;
                        r_out_l     <= r_left;
                        r_out_r     <= r_right;
                        r_out_fin   <= r_fin;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
